// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VTSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VTSM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/vtsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vtsm_pkg;

  localparam int DIM_W          = 12;
  localparam int PIX_W          = 11;
  localparam int PROG_W         = 8;
  localparam int MODE_W         = 4;
  localparam int MASK_W         = 9;
  localparam int F_W            = 17;
  localparam int FRAC_W         = 16;
  localparam int DIV_W          = DIM_W + FRAC_W;
  localparam int PROD_W         = PIX_W + DIV_W;
  localparam int DOT_W          = DIM_W;
  localparam int DOTK_W         = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 12;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int QUEUE_DEPTH    = 4;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int THIRD_RECIP    = 2731;
  localparam int THIRD_SHIFT    = 13;
  localparam int DOT_LEVELS     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRESS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MASK   = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_KEEP      = 4'd0,
    MODE_CROSSFADE = 4'd1,
    MODE_PUSH_LR   = 4'd2,
    MODE_PUSH_RL   = 4'd3,
    MODE_PUSH_TB   = 4'd4,
    MODE_PUSH_BT   = 4'd5,
    MODE_BLOCKS    = 4'd6,
    MODE_SPLIT     = 4'd7,
    MODE_CENTRE    = 4'd8,
    MODE_SQUEEZE   = 4'd9,
    MODE_WIPE_LR   = 4'd10,
    MODE_WIPE_RL   = 4'd11,
    MODE_WIPE_TB   = 4'd12,
    MODE_WIPE_BT   = 4'd13,
    MODE_DOTS      = 4'd14
  } mode_e;

  typedef enum logic [1:0] {
    SRC_OUT   = 2'd0,
    SRC_IN    = 2'd1,
    SRC_BLEND = 2'd2,
    SRC_KEEP  = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_SQUEEZE = 2'd1,
    KIND_DOT     = 2'd2
  } kind_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        source;
    logic [PIX_W-1:0]  source_x;
    logic [PIX_W-1:0]  source_y;
    logic [PROG_W-1:0] blend_weight;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  iw;
    logic [DIM_W-1:0]  ih;
    logic [DIM_W-1:0]  ihalf;
    logic [DIM_W-1:0]  w_m_iw;
    logic [DIM_W-1:0]  h_m_ih;
    logic [DIM_W-1:0]  w_m_ihalf;
    logic [DIM_W-1:0]  half_w;
    logic [DIM_W-1:0]  half_h;
    logic [DIM_W:0]    tw;
    logic [DIM_W:0]    tw2;
    logic [DIM_W:0]    th;
    logic [DIM_W:0]    th2;
    logic [PIX_W-1:0]  ctr_l;
    logic [PIX_W-1:0]  ctr_r;
    logic [DIV_W-1:0]  d1;
    logic [DIV_W-1:0]  d2;
    logic [PROG_W-1:0] progress;
    logic [MODE_W-1:0] mode;
    logic [MASK_W-1:0] mask;
    logic              dots_out;
    logic [DOTK_W-1:0] dot_k;
  } params_t;

  typedef struct packed {
    kind_e             kind;
    logic [1:0]        source;
    logic [PIX_W-1:0]  sx;
    logic [PIX_W-1:0]  sy;
    logic [PROG_W-1:0] wgt;
    logic [PIX_W-1:0]  mul_a;
    logic              use_d2;
  } job_t;

  typedef logic [F_W-1:0] smooth_tbl_t [256];

  function automatic logic [F_W-1:0] smooth_q16(input int unsigned n);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned f;
    longint          s;
    x    = (64'd3373259426 * longint'(n)) / 64'd510;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int k = 1; k <= 10; k++) begin
      term = (term * x2) >> 30;
      case (k)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        8:       term = term / 64'd272;
        9:       term = term / 64'd342;
        default: term = term / 64'd420;
      endcase
      if (k[0]) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    f = ((longint'(s) * longint'(s)) + (64'd1 << 43)) >> 44;
    if (f > 64'd65536) f = 64'd65536;
    return F_W'(f);
  endfunction

  function automatic smooth_tbl_t make_smooth_tbl();
    smooth_tbl_t t;
    for (int n = 0; n < 256; n++) begin
      t[n] = smooth_q16(n);
    end
    return t;
  endfunction

  localparam smooth_tbl_t SMOOTH_TBL = make_smooth_tbl();

  // Inverse of 2^k+1 modulo 2^12 and the largest residue that marks a multiple.
  function automatic logic [DOT_W-1:0] dot_inv(input logic [DOTK_W-1:0] k);
    logic [DOT_W-1:0] r;
    case (k)
      3'd1:    r = 12'd2731;
      3'd2:    r = 12'd3277;
      3'd3:    r = 12'd3641;
      3'd4:    r = 12'd241;
      3'd5:    r = 12'd993;
      3'd6:    r = 12'd4033;
      3'd7:    r = 12'd3969;
      default: r = 12'd1;
    endcase
    return r;
  endfunction

  function automatic logic [DOT_W-1:0] dot_lim(input logic [DOTK_W-1:0] k);
    logic [DOT_W-1:0] r;
    case (k)
      3'd1:    r = 12'd1365;
      3'd2:    r = 12'd819;
      3'd3:    r = 12'd455;
      3'd4:    r = 12'd240;
      3'd5:    r = 12'd124;
      3'd6:    r = 12'd63;
      3'd7:    r = 12'd31;
      default: r = 12'd2047;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/video_transition_source_mapper.sv -----
// Channel | Ports                                  | Moves
// input   | in_valid, in_ready, in_data            | pixel_x, pixel_y request
// result  | out_valid, out_ready, out_data         | source, source_x/y, blend_weight
// config  | cfg_we, cfg_index, cfg_wdata           | one register write per cycle
// One pixel per clock sustained while the parameter unit is done and neither side stalls;
// a taken request passes the queue, the multiply stage and the output register to out_valid.
// After reset and after each register write the parameter unit steps through lookup,
// multiply, derive and two 28-step divisions with in_ready low.
// A four-entry queue parts classification from the back end, so either side may stall.
`timescale 1ns / 1ps
`default_nettype none

module video_transition_source_mapper #(
  parameter int MAX_WIDTH  = vtsm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = vtsm_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire vtsm_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output vtsm_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [vtsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vtsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  vtsm_pkg::params_t params;
  logic              setup_ready;
  vtsm_pkg::job_t    front_job, head_job;
  logic              q_full, q_valid, q_pop, push;

  vtsm_setup #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .params   (params),
    .ready    (setup_ready)
  );

  vtsm_front u_front (
    .in_item(in_data),
    .params (params),
    .job    (front_job)
  );

  assign in_ready = setup_ready && !q_full && !cfg_we;
  assign push     = in_valid && in_ready;

  vtsm_queue #(
    .DEPTH(vtsm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(front_job),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (head_job)
  );

  logic back_ready;

  assign q_pop = q_valid && back_ready;

  vtsm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .params   (params),
    .job_valid(q_valid),
    .job      (head_job),
    .job_ready(back_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- hdl/vtsm_setup.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vtsm_setup #(
  parameter int MAX_WIDTH  = vtsm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = vtsm_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [vtsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vtsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output vtsm_pkg::params_t                     params,
  output logic                                  ready
);

  localparam int DW    = vtsm_pkg::DIM_W;
  localparam int PW    = vtsm_pkg::PIX_W;
  localparam int QW    = vtsm_pkg::DIV_W;
  localparam int FW    = vtsm_pkg::F_W;
  localparam int FR    = vtsm_pkg::FRAC_W;
  localparam int CNT_W = $clog2(QW);

  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_DERIVE = 6'b000100,
    ST_DIV1   = 6'b001000,
    ST_DIV2   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t st_r, st_nxt;

  logic [DW-1:0]                    width_r, width_nxt;
  logic [DW-1:0]                    height_r, height_nxt;
  logic [vtsm_pkg::MODE_W-1:0]      mode_r, mode_nxt;
  logic [vtsm_pkg::PROG_W-1:0]      prog_r, prog_nxt;
  logic [vtsm_pkg::MASK_W-1:0]      mask_r, mask_nxt;

  logic [DW-1:0]    w_r, h_r, iw_r, ih_r, ihalf_r;
  logic [DW-1:0]    w_m_iw_r, h_m_ih_r, w_m_ihalf_r;
  logic [DW-1:0]    tw_r, th_r;
  logic [PW-1:0]    ctr_l_r, ctr_r_r;
  logic [FW-1:0]    f_r;
  logic [3:0]       kraw_r;
  logic             dots_out_r;
  logic [vtsm_pkg::DOTK_W-1:0] dot_k_r;
  logic [QW-1:0]    d1_r, d2_r, dvd_r, dvd_nxt;
  logic [DW-1:0]    rem_r, rem_nxt, div_den;
  logic [DW:0]      rem_sh;
  logic             ge;
  logic [CNT_W-1:0] cnt_r;
  logic             div_last;

  logic [FW+DW-1:0] fw, fh;
  logic [FW+2:0]    f5;
  logic [2*DW-1:0]  twp, thp;
  logic [DW-1:0]    half_w, half_h;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v, input int lim);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) r = {{(DW-1){1'b0}}, 1'b1};
    else if (32'(v) > 32'(lim)) r = DW'(lim);
    return r;
  endfunction

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    mode_nxt   = mode_r;
    prog_nxt   = prog_r;
    mask_nxt   = mask_r;
    if (cfg_we) begin
      case (cfg_index)
        vtsm_pkg::CFG_FRAME_WIDTH:  width_nxt  = cfg_wdata[DW-1:0];
        vtsm_pkg::CFG_FRAME_HEIGHT: height_nxt = cfg_wdata[DW-1:0];
        vtsm_pkg::CFG_MODE:         mode_nxt   = cfg_wdata[vtsm_pkg::MODE_W-1:0];
        vtsm_pkg::CFG_PROGRESS:     prog_nxt   = cfg_wdata[vtsm_pkg::PROG_W-1:0];
        vtsm_pkg::CFG_BLOCK_MASK:   mask_nxt   = cfg_wdata[vtsm_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign div_last = (cnt_r == CNT_W'(QW - 1));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_LOAD:   st_nxt = ST_MUL;
      ST_MUL:    st_nxt = ST_DERIVE;
      ST_DERIVE: st_nxt = ST_DIV1;
      ST_DIV1:   if (div_last) st_nxt = ST_DIV2;
      ST_DIV2:   if (div_last) st_nxt = ST_DONE;
      ST_DONE:   st_nxt = ST_DONE;
      default:   st_nxt = ST_LOAD;
    endcase
    if (cfg_we) st_nxt = ST_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_LOAD;
      width_r  <= DW'(vtsm_pkg::RESET_WIDTH);
      height_r <= DW'(vtsm_pkg::RESET_HEIGHT);
      mode_r   <= vtsm_pkg::MODE_KEEP;
      prog_r   <= '0;
      mask_r   <= '0;
    end else begin
      st_r     <= st_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      mode_r   <= mode_nxt;
      prog_r   <= prog_nxt;
      mask_r   <= mask_nxt;
    end
  end

  assign fw     = f_r * w_r;
  assign fh     = f_r * h_r;
  assign f5     = f_r * 3'd5;
  assign twp    = w_r * DW'(vtsm_pkg::THIRD_RECIP);
  assign thp    = h_r * DW'(vtsm_pkg::THIRD_RECIP);
  assign half_w = {1'b0, w_r[DW-1:1]};
  assign half_h = {1'b0, h_r[DW-1:1]};

  assign div_den = (st_r == ST_DIV2) ? (w_r - {ihalf_r[DW-2:0], 1'b0}) : ihalf_r;
  assign rem_sh  = {rem_r, dvd_r[QW-1]};
  assign ge      = (rem_sh >= {1'b0, div_den});
  assign rem_nxt = ge ? DW'(rem_sh - {1'b0, div_den}) : rem_sh[DW-1:0];
  assign dvd_nxt = {dvd_r[QW-2:0], ge};

  always_ff @(posedge clk) begin
    case (st_r)
      ST_LOAD: begin
        w_r <= clamp_dim(width_r, MAX_WIDTH);
        h_r <= clamp_dim(height_r, MAX_HEIGHT);
        f_r <= vtsm_pkg::SMOOTH_TBL[prog_r];
      end
      ST_MUL: begin
        iw_r    <= fw[FR+DW-1:FR];
        ihalf_r <= fw[FR+DW:FR+1];
        ih_r    <= fh[FR+DW-1:FR];
        tw_r    <= DW'(twp >> vtsm_pkg::THIRD_SHIFT);
        th_r    <= DW'(thp >> vtsm_pkg::THIRD_SHIFT);
        kraw_r  <= f5[FR+3:FR];
      end
      ST_DERIVE: begin
        w_m_iw_r    <= w_r - iw_r;
        h_m_ih_r    <= h_r - ih_r;
        w_m_ihalf_r <= w_r - ihalf_r;
        ctr_l_r     <= PW'(w_r - half_w - ihalf_r);
        ctr_r_r     <= PW'(half_w - w_r + ihalf_r);
        if (kraw_r < 4'(vtsm_pkg::DOT_LEVELS)) begin
          dots_out_r <= 1'b0;
          dot_k_r    <= vtsm_pkg::DOTK_W'(4'(vtsm_pkg::DOT_LEVELS - 1) - kraw_r);
        end else begin
          dots_out_r <= 1'b1;
          dot_k_r    <= '0;
        end
        dvd_r <= {half_w, {FR{1'b0}}};
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV1: begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (div_last) begin
          d1_r  <= dvd_nxt;
          dvd_r <= {w_r, {FR{1'b0}}};
          rem_r <= '0;
          cnt_r <= '0;
        end
      end
      ST_DIV2: begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (div_last) begin
          d2_r <= dvd_nxt;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    params.w         = w_r;
    params.h         = h_r;
    params.iw        = iw_r;
    params.ih        = ih_r;
    params.ihalf     = ihalf_r;
    params.w_m_iw    = w_m_iw_r;
    params.h_m_ih    = h_m_ih_r;
    params.w_m_ihalf = w_m_ihalf_r;
    params.half_w    = half_w;
    params.half_h    = half_h;
    params.tw        = {1'b0, tw_r};
    params.tw2       = {tw_r, 1'b0};
    params.th        = {1'b0, th_r};
    params.th2       = {th_r, 1'b0};
    params.ctr_l     = ctr_l_r;
    params.ctr_r     = ctr_r_r;
    params.d1        = d1_r;
    params.d2        = d2_r;
    params.progress  = prog_r;
    params.mode      = mode_r;
    params.mask      = mask_r;
    params.dots_out  = dots_out_r;
    params.dot_k     = dot_k_r;
  end

  assign ready = (st_r == ST_DONE);

  `VTSM_ASSERT_NXT(a_done_holds, clk, rst_n, (st_r == ST_DONE) && !cfg_we,
                   st_r == ST_DONE, "parameter unit left done without a write")
  `VTSM_ASSERT_NXT(a_write_restarts, clk, rst_n, cfg_we, st_r == ST_LOAD,
                   "write did not restart parameter unit")

endmodule

`default_nettype wire

// ----- hdl/vtsm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vtsm_front (
  input  wire vtsm_pkg::in_item_t  in_item,
  input  wire vtsm_pkg::params_t   params,
  output vtsm_pkg::job_t           job
);

  localparam int DW = vtsm_pkg::DIM_W;
  localparam int PW = vtsm_pkg::PIX_W;

  logic [DW-1:0] xe, ye;
  logic          in_frame;
  logic          lr_in, rl_out, tb_in, bt_out;
  logic [DW-1:0] lr_sx, rl_sx, tb_sy, bt_sy;
  logic [1:0]    col, row;
  logic [3:0]    blk;

  assign xe = {1'b0, in_item.pixel_x};
  assign ye = {1'b0, in_item.pixel_y};
  assign in_frame = (xe < params.w) && (ye < params.h);

  assign lr_in  = xe < params.iw;
  assign lr_sx  = lr_in ? (xe + params.w_m_iw) : (xe - params.iw);
  assign rl_out = xe < params.w_m_iw;
  assign rl_sx  = rl_out ? (xe + params.iw) : (xe - params.w_m_iw);
  assign tb_in  = ye < params.ih;
  assign tb_sy  = tb_in ? (ye + params.h_m_ih) : (ye - params.ih);
  assign bt_out = ye < params.h_m_ih;
  assign bt_sy  = bt_out ? (ye + params.ih) : (ye - params.h_m_ih);

  assign col = ({1'b0, xe} < params.tw) ? 2'd0 : (({1'b0, xe} < params.tw2) ? 2'd1 : 2'd2);
  assign row = ({1'b0, ye} < params.th) ? 2'd0 : (({1'b0, ye} < params.th2) ? 2'd1 : 2'd2);
  assign blk = {2'b00, row} * 4'd3 + {2'b00, col};

  always_comb begin
    job.kind   = vtsm_pkg::KIND_PLAIN;
    job.source = vtsm_pkg::SRC_KEEP;
    job.sx     = in_item.pixel_x;
    job.sy     = in_item.pixel_y;
    job.wgt    = '0;
    job.mul_a  = '0;
    job.use_d2 = 1'b0;
    if (in_frame) begin
      case (params.mode)
        vtsm_pkg::MODE_CROSSFADE: begin
          job.source = vtsm_pkg::SRC_BLEND;
          job.wgt    = params.progress;
        end
        vtsm_pkg::MODE_PUSH_LR: begin
          job.source = lr_in ? vtsm_pkg::SRC_IN : vtsm_pkg::SRC_OUT;
          job.sx     = lr_sx[PW-1:0];
        end
        vtsm_pkg::MODE_PUSH_RL: begin
          job.source = rl_out ? vtsm_pkg::SRC_OUT : vtsm_pkg::SRC_IN;
          job.sx     = rl_sx[PW-1:0];
        end
        vtsm_pkg::MODE_PUSH_TB: begin
          job.source = tb_in ? vtsm_pkg::SRC_IN : vtsm_pkg::SRC_OUT;
          job.sy     = tb_sy[PW-1:0];
        end
        vtsm_pkg::MODE_PUSH_BT: begin
          job.source = bt_out ? vtsm_pkg::SRC_OUT : vtsm_pkg::SRC_IN;
          job.sy     = bt_sy[PW-1:0];
        end
        vtsm_pkg::MODE_BLOCKS: begin
          job.source = params.mask[blk] ? vtsm_pkg::SRC_IN : vtsm_pkg::SRC_OUT;
        end
        vtsm_pkg::MODE_SPLIT: begin
          if (ye < params.half_h) begin
            job.source = lr_in ? vtsm_pkg::SRC_IN : vtsm_pkg::SRC_OUT;
            job.sx     = lr_sx[PW-1:0];
          end else begin
            job.source = rl_out ? vtsm_pkg::SRC_OUT : vtsm_pkg::SRC_IN;
            job.sx     = rl_sx[PW-1:0];
          end
        end
        vtsm_pkg::MODE_CENTRE: begin
          if (xe < params.ihalf) begin
            job.source = vtsm_pkg::SRC_IN;
            job.sx     = params.ctr_l + in_item.pixel_x;
          end else if (xe >= params.w_m_ihalf) begin
            job.source = vtsm_pkg::SRC_IN;
            job.sx     = params.ctr_r + in_item.pixel_x;
          end else begin
            job.source = vtsm_pkg::SRC_OUT;
          end
        end
        vtsm_pkg::MODE_SQUEEZE: begin
          job.kind = vtsm_pkg::KIND_SQUEEZE;
          if (xe < params.ihalf) begin
            job.source = vtsm_pkg::SRC_IN;
            job.sx     = '0;
            job.mul_a  = in_item.pixel_x;
          end else if (xe >= params.w_m_ihalf) begin
            job.source = vtsm_pkg::SRC_IN;
            job.sx     = params.half_w[PW-1:0];
            job.mul_a  = PW'(xe - params.w_m_ihalf);
          end else begin
            job.source = vtsm_pkg::SRC_OUT;
            job.sx     = '0;
            job.mul_a  = PW'(xe - params.ihalf);
            job.use_d2 = 1'b1;
          end
        end
        vtsm_pkg::MODE_WIPE_LR: job.source = lr_in ? vtsm_pkg::SRC_IN : vtsm_pkg::SRC_OUT;
        vtsm_pkg::MODE_WIPE_RL: job.source = rl_out ? vtsm_pkg::SRC_OUT : vtsm_pkg::SRC_IN;
        vtsm_pkg::MODE_WIPE_TB: job.source = tb_in ? vtsm_pkg::SRC_IN : vtsm_pkg::SRC_OUT;
        vtsm_pkg::MODE_WIPE_BT: job.source = bt_out ? vtsm_pkg::SRC_OUT : vtsm_pkg::SRC_IN;
        vtsm_pkg::MODE_DOTS: begin
          job.kind = vtsm_pkg::KIND_DOT;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/vtsm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vtsm_queue #(
  parameter int DEPTH = vtsm_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire vtsm_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output vtsm_pkg::job_t       head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vtsm_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign full  = (cnt_r == CW'(DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop) rd_ptr_r <= bump(rd_ptr_r);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  `VTSM_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full, "request pushed into full queue")
  `VTSM_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, valid, "request popped from empty queue")
  `VTSM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH),
                   "queue count beyond depth")

endmodule

`default_nettype wire

// ----- hdl/vtsm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vtsm_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire vtsm_pkg::params_t  params,
  input  wire logic               job_valid,
  input  wire vtsm_pkg::job_t     job,
  output logic                    job_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output vtsm_pkg::out_item_t     out_data
);

  localparam int PW = vtsm_pkg::PIX_W;
  localparam int QW = vtsm_pkg::DIV_W;
  localparam int MW = vtsm_pkg::PROD_W;
  localparam int TW = vtsm_pkg::DOT_W;
  localparam int FR = vtsm_pkg::FRAC_W;

  logic                s1_v_r;
  vtsm_pkg::job_t      s1_job_r;
  logic [MW-1:0]       prod_r;
  logic [TW-1:0]       mx_r, my_r;
  logic                out_v_r;
  vtsm_pkg::out_item_t out_r, out_nxt;

  logic          s2_ready;
  logic [QW-1:0] dsel;
  logic [MW-1:0] prod;
  logic [TW-1:0] vx, vy, inv, lim;
  logic [2*TW-1:0] px, py;
  logic          hit;

  assign s2_ready  = !out_v_r || out_ready;
  assign job_ready = !s1_v_r || s2_ready;

  assign dsel = job.use_d2 ? params.d2 : params.d1;
  assign prod = job.mul_a * dsel;
  assign inv  = vtsm_pkg::dot_inv(params.dot_k);
  assign lim  = vtsm_pkg::dot_lim(params.dot_k);
  assign vx   = {1'b0, job.sx} + 1'b1;
  assign vy   = {1'b0, job.sy} + 1'b1;
  assign px   = vx * inv;
  assign py   = vy * inv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (job_ready) s1_v_r <= job_valid;
      if (s2_ready) out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      s1_job_r <= job;
      prod_r   <= prod;
      mx_r     <= px[TW-1:0];
      my_r     <= py[TW-1:0];
    end
    if (s2_ready && s1_v_r) out_r <= out_nxt;
  end

  always_comb begin
    if (params.dot_k == '0) hit = !(~s1_job_r.sx[0]) && !(~s1_job_r.sy[0]);
    else hit = (mx_r <= lim) && (my_r <= lim);
  end

  always_comb begin
    out_nxt.source       = s1_job_r.source;
    out_nxt.source_x     = s1_job_r.sx;
    out_nxt.source_y     = s1_job_r.sy;
    out_nxt.blend_weight = s1_job_r.wgt;
    case (s1_job_r.kind)
      vtsm_pkg::KIND_PLAIN: ;
      vtsm_pkg::KIND_SQUEEZE: out_nxt.source_x = s1_job_r.sx + prod_r[FR+PW-1:FR];
      vtsm_pkg::KIND_DOT: begin
        if (hit) out_nxt.source = params.dots_out ? vtsm_pkg::SRC_OUT : vtsm_pkg::SRC_IN;
        else out_nxt.source = params.dots_out ? vtsm_pkg::SRC_IN : vtsm_pkg::SRC_OUT;
      end
      default: ;
    endcase
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `VTSM_ASSERT_NXT(a_s1_holds, clk, rst_n, s1_v_r && !s2_ready, s1_v_r && $stable(s1_job_r),
                   "stalled request lost in multiply stage")

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import vtsm_pkg::*;

  typedef struct {
    bit              skip_cfg;
    int unsigned     w;
    int unsigned     h;
    int unsigned     mode;
    int unsigned     prog;
    int unsigned     mask;
    int unsigned     px;
    int unsigned     py;
    bit              chk;
    out_item_t       exp;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic [DIM_W-1:0]  cur_w;
  logic [DIM_W-1:0]  cur_h;
  logic [MODE_W-1:0] cur_mode;
  logic [PROG_W-1:0] cur_prog;
  logic [MASK_W-1:0] cur_mask;

  out_item_t   pending_src_q[$];
  int          fail_cnt;
  int          snd_pct;
  int          rcv_pct;
  int          hold_cnt;
  int          stall_cycles;
  dir_row_t    dir_rows[];

  video_transition_source_mapper u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned smooth_frac(input int unsigned n);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned tk;
    longint unsigned fr;
    longint          acc;
    ang  = (64'd3373259426 * n) / 64'd510;
    ang2 = (ang * ang) >> 30;
    tk   = ang;
    acc  = longint'(ang);
    for (int k = 1; k <= 10; k++) begin
      tk = (tk * ang2) >> 30;
      tk = tk / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(tk);
      else acc = acc + longint'(tk);
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sd1073741824) acc = 64'sd1073741824;
    fr = (longint'(acc) * longint'(acc) + (64'd1 << 43)) >> 44;
    if (fr > 64'd65536) fr = 64'd65536;
    return fr;
  endfunction

  function automatic out_item_t predict_source(input in_item_t p);
    longint unsigned x, y, fw, fh, fr, iw, ih, ihalf, sx, sy, d, tw, th, c, r, per;
    longint          k;
    logic [1:0]      src;
    logic [7:0]      wgt;
    bit              dots_out;
    out_item_t       o;
    x   = p.pixel_x;
    y   = p.pixel_y;
    fw  = cur_w;
    fh  = cur_h;
    src = SRC_KEEP;
    sx  = x;
    sy  = y;
    wgt = 0;
    if (fw < 1) fw = 1;
    if (fw > 2048) fw = 2048;
    if (fh < 1) fh = 1;
    if (fh > 2048) fh = 2048;
    fr    = smooth_frac(cur_prog);
    iw    = (fr * fw) >> 16;
    ih    = (fr * fh) >> 16;
    ihalf = (fr * fw) >> 17;
    if (x < fw && y < fh) begin
      case (cur_mode)
        MODE_CROSSFADE: begin
          src = SRC_BLEND;
          wgt = cur_prog;
        end
        MODE_PUSH_LR: begin
          if (x < iw) begin src = SRC_IN; sx = x + fw - iw; end
          else begin src = SRC_OUT; sx = x - iw; end
        end
        MODE_PUSH_RL: begin
          if (x < fw - iw) begin src = SRC_OUT; sx = x + iw; end
          else begin src = SRC_IN; sx = x - (fw - iw); end
        end
        MODE_PUSH_TB: begin
          if (y < ih) begin src = SRC_IN; sy = y + fh - ih; end
          else begin src = SRC_OUT; sy = y - ih; end
        end
        MODE_PUSH_BT: begin
          if (y < fh - ih) begin src = SRC_OUT; sy = y + ih; end
          else begin src = SRC_IN; sy = y - (fh - ih); end
        end
        MODE_BLOCKS: begin
          tw  = fw / 3;
          th  = fh / 3;
          c   = (x < tw) ? 0 : ((x < 2 * tw) ? 1 : 2);
          r   = (y < th) ? 0 : ((y < 2 * th) ? 1 : 2);
          src = cur_mask[r * 3 + c] ? SRC_IN : SRC_OUT;
        end
        MODE_SPLIT: begin
          if (y < fh / 2) begin
            if (x < iw) begin src = SRC_IN; sx = x + fw - iw; end
            else begin src = SRC_OUT; sx = x - iw; end
          end else begin
            if (x < fw - iw) begin src = SRC_OUT; sx = x + iw; end
            else begin src = SRC_IN; sx = x - (fw - iw); end
          end
        end
        MODE_CENTRE: begin
          if (x < ihalf) begin src = SRC_IN; sx = fw - fw / 2 - ihalf + x; end
          else if (x >= fw - ihalf) begin src = SRC_IN; sx = fw / 2 + x - (fw - ihalf); end
          else src = SRC_OUT;
        end
        MODE_SQUEEZE: begin
          if (x < ihalf) begin
            d = ((fw / 2) << 16) / ihalf;
            src = SRC_IN;
            sx = (x * d) >> 16;
          end else if (x >= fw - ihalf) begin
            d = ((fw / 2) << 16) / ihalf;
            src = SRC_IN;
            sx = fw / 2 + (((x - (fw - ihalf)) * d) >> 16);
          end else begin
            d = (fw << 16) / (fw - 2 * ihalf);
            src = SRC_OUT;
            sx = ((x - ihalf) * d) >> 16;
          end
        end
        MODE_WIPE_LR: src = (x < iw) ? SRC_IN : SRC_OUT;
        MODE_WIPE_RL: src = (x < fw - iw) ? SRC_OUT : SRC_IN;
        MODE_WIPE_TB: src = (y < ih) ? SRC_IN : SRC_OUT;
        MODE_WIPE_BT: src = (y < fh - ih) ? SRC_OUT : SRC_IN;
        MODE_DOTS: begin
          k        = longint'((fr * 5) >> 16) - 5;
          dots_out = 1'b1;
          if (k < 0) begin
            dots_out = 1'b0;
            k = -(k + 1);
          end
          per = (64'd1 << (k & 7)) + 1;
          if ((y + 1) % per == 0 && (x + 1) % per == 0)
            src = dots_out ? SRC_OUT : SRC_IN;
          else
            src = dots_out ? SRC_IN : SRC_OUT;
        end
        default: src = SRC_KEEP;
      endcase
    end
    o.source       = src;
    o.source_x     = sx[PIX_W-1:0];
    o.source_y     = sy[PIX_W-1:0];
    o.blend_weight = wgt;
    return o;
  endfunction

  function automatic dir_row_t mk_row(bit skip, int unsigned w, int unsigned h,
                                      int unsigned mode, int unsigned prog,
                                      int unsigned mask, int unsigned px,
                                      int unsigned py, bit chk, src_e s,
                                      int unsigned sx, int unsigned sy,
                                      int unsigned wgt);
    dir_row_t rw;
    rw.skip_cfg = skip;
    rw.w = w; rw.h = h; rw.mode = mode; rw.prog = prog; rw.mask = mask;
    rw.px = px; rw.py = py; rw.chk = chk;
    rw.exp.source = s;
    rw.exp.source_x = sx;
    rw.exp.source_y = sy;
    rw.exp.blend_weight = wgt;
    return rw;
  endfunction

  task automatic set_config(input int unsigned w, input int unsigned h,
                            input int unsigned mode, input int unsigned prog,
                            input int unsigned mask);
    int unsigned vals[5];
    vals = '{w, h, mode, prog, mask};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
    end
    cfg_index <= CFG_IDX_W'($urandom_range(7, 5));
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_w    = w;
    cur_h    = h;
    cur_mode = mode;
    cur_prog = prog;
    cur_mask = mask;
  endtask

  task automatic send_request(input in_item_t d, input bit typed, input out_item_t texp);
    bit rdy;
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    forever begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
      if (rdy) break;
    end
    pending_src_q.push_back(typed ? texp : predict_source(d));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_src_q.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(9))
      0: return 0;
      1: return 1;
      2: return 2048;
      3: return $urandom_range(4095, 2049);
      4: return $urandom_range(16, 1);
      default: return $urandom_range(2048, 1);
    endcase
  endfunction

  function automatic int unsigned pick_prog();
    case ($urandom_range(7))
      0: return 0;
      1: return 255;
      2: return 1;
      3: return 254;
      default: return $urandom_range(255);
    endcase
  endfunction

  always begin
    @(negedge clk);
    if (out_valid && out_ready) begin
      if (pending_src_q.size() == 0) begin
        $error("unexpected result source=%0d", out_data.source);
        fail_cnt++;
      end else begin
        out_item_t e;
        e = pending_src_q.pop_front();
        if (out_data.source !== e.source) begin
          $error("source exp %0d got %0d", e.source, out_data.source);
          fail_cnt++;
        end
        if (out_data.source_x !== e.source_x) begin
          $error("source_x exp %0d got %0d", e.source_x, out_data.source_x);
          fail_cnt++;
        end
        if (out_data.source_y !== e.source_y) begin
          $error("source_y exp %0d got %0d", e.source_y, out_data.source_y);
          fail_cnt++;
        end
        if (out_data.blend_weight !== e.blend_weight) begin
          $error("blend_weight exp %0d got %0d", e.blend_weight, out_data.blend_weight);
          fail_cnt++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= 5000) begin
      $display("FAIL video_transition_source_mapper");
      $finish;
    end
    @(posedge clk);
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt--;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  initial begin
    in_item_t    px;
    int unsigned ew;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    fail_cnt     = 0;
    snd_pct      = 13;
    rcv_pct      = 85;
    hold_cnt     = 0;
    stall_cycles = 0;
    cur_w        = 640;
    cur_h        = 480;
    cur_mode     = MODE_KEEP;
    cur_prog     = 0;
    cur_mask     = 0;
    dir_rows = '{
      mk_row(1, 640, 480, MODE_KEEP, 0, 0, 5, 7, 1, SRC_KEEP, 5, 7, 0),
      mk_row(0, 640, 480, MODE_CROSSFADE, 100, 0, 640, 10, 1, SRC_KEEP, 640, 10, 0),
      mk_row(0, 640, 480, MODE_PUSH_LR, 100, 0, 3, 480, 1, SRC_KEEP, 3, 480, 0),
      mk_row(0, 640, 480, MODE_CROSSFADE, 200, 0, 10, 10, 1, SRC_BLEND, 10, 10, 200),
      mk_row(0, 640, 480, 15, 50, 0, 7, 8, 1, SRC_KEEP, 7, 8, 0),
      mk_row(0, 640, 480, MODE_PUSH_LR, 0, 0, 100, 9, 1, SRC_OUT, 100, 9, 0),
      mk_row(0, 640, 480, MODE_PUSH_LR, 255, 0, 100, 9, 1, SRC_IN, 100, 9, 0),
      mk_row(0, 0, 480, MODE_CROSSFADE, 9, 0, 0, 0, 1, SRC_BLEND, 0, 0, 9),
      mk_row(0, 4095, 4095, MODE_CROSSFADE, 255, 0, 2047, 2047, 1,
             SRC_BLEND, 2047, 2047, 255),
      mk_row(0, 640, 480, MODE_PUSH_RL, 128, 0, 600, 20, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_PUSH_TB, 128, 0, 30, 50, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_PUSH_BT, 128, 0, 30, 400, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_BLOCKS, 77, 341, 500, 400, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_SPLIT, 90, 0, 620, 300, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_CENTRE, 160, 0, 630, 100, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_SQUEEZE, 255, 0, 320, 100, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 641, 480, MODE_SQUEEZE, 100, 0, 321, 100, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_WIPE_LR, 128, 0, 200, 5, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_WIPE_RL, 128, 0, 500, 5, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_WIPE_TB, 128, 0, 5, 100, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_WIPE_BT, 128, 0, 5, 400, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_DOTS, 0, 0, 16, 16, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_DOTS, 255, 0, 1, 1, 0, SRC_OUT, 0, 0, 0),
      mk_row(0, 640, 480, MODE_DOTS, 128, 0, 1, 1, 0, SRC_OUT, 0, 0, 0)
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (!dir_rows[i].skip_cfg)
        set_config(dir_rows[i].w, dir_rows[i].h, dir_rows[i].mode,
                   dir_rows[i].prog, dir_rows[i].mask);
      px.pixel_x = dir_rows[i].px;
      px.pixel_y = dir_rows[i].py;
      send_request(px, dir_rows[i].chk, dir_rows[i].exp);
      wait_drain();
    end

    for (int ph = 0; ph < 30; ph++) begin
      if (ph < 10) begin snd_pct = 13; rcv_pct = 85; end
      else if (ph < 20) begin snd_pct = 85; rcv_pct = 13; end
      else begin snd_pct = 0; rcv_pct = 0; end
      set_config(pick_dim(), pick_dim(), $urandom_range(15), pick_prog(),
                 $urandom_range(511));
      if (ph == 20) hold_cnt = 300;
      ew = (cur_w == 0) ? 1 : ((cur_w > 2048) ? 2048 : cur_w);
      for (int j = 0; j < 40; j++) begin
        if ($urandom_range(9) < 8) begin
          px.pixel_x = $urandom_range(ew - 1);
          px.pixel_y = $urandom_range(((cur_h == 0) ? 1 :
                                       ((cur_h > 2048) ? 2048 : cur_h)) - 1);
        end else begin
          px.pixel_x = $urandom;
          px.pixel_y = $urandom;
        end
        send_request(px, 1'b0, '0);
      end
      wait_drain();
    end

    repeat (20) @(posedge clk);
    if (fail_cnt == 0) $display("PASS video_transition_source_mapper");
    else $display("FAIL video_transition_source_mapper");
    $finish;
  end

endmodule

// ----- video_transition_source_mapper.f -----
+incdir+hdl
hdl/vtsm_pkg.sv
hdl/vtsm_setup.sv
hdl/vtsm_front.sv
hdl/vtsm_queue.sv
hdl/vtsm_back.sv
hdl/video_transition_source_mapper.sv
test/tb_top.sv
